// ----- sv/kuid_pkg.sv -----
package kuid_pkg;

	// Number of keys the lookup table can hold.
	localparam int TABLE_ENTRIES = 16;

	// Widths of the request fields as they arrive on the port.
	localparam int INST_IN_W   = 4;
	localparam int FUNC_IN_W   = 6;
	localparam int ZONE_IN_W   = 11;
	localparam int SECONDS_W   = 32;

	// Widths of the fields inside the packed identifier.
	localparam int INST_W      = 3;
	localparam int FUNC_W      = 5;
	localparam int ZONE_W      = 10;
	localparam int SERIAL_W    = 16;
	localparam int SEC_ID_W    = 30;
	localparam int KEY_W       = INST_W + FUNC_W + ZONE_W;
	localparam int ID_W        = INST_W + FUNC_W + ZONE_W + SERIAL_W + SEC_ID_W;

	// The stored serial has one extra bit so that it can hold the limit itself.
	localparam int SERIAL_CNT_W = SERIAL_W + 1;

	localparam int STATUS_W    = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_NOT_READY = 3'd1,
		ST_TOO_BIG   = 3'd2,
		ST_BUSY      = 3'd3,
		ST_NO_ROOM   = 3'd4
	} status_t;

	typedef logic [TABLE_ENTRIES-1:0] entry_vec_t;

endpackage

// ----- sv/kuid_req_if.sv -----
interface kuid_req_if;
	import kuid_pkg::*;

	logic                 valid;
	logic                 ready;
	logic [INST_IN_W-1:0] instance_id;
	logic [FUNC_IN_W-1:0] function_id;
	logic [ZONE_IN_W-1:0] zone_number;
	logic [SECONDS_W-1:0] now_seconds;

	modport source (
		output valid, instance_id, function_id, zone_number, now_seconds,
		input  ready
	);

	modport sink (
		input  valid, instance_id, function_id, zone_number, now_seconds,
		output ready
	);

endinterface

// ----- sv/kuid_rsp_if.sv -----
interface kuid_rsp_if;
	import kuid_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [ID_W-1:0]     id_value;

	modport source (
		output valid, status, id_value,
		input  ready
	);

	modport sink (
		input  valid, status, id_value,
		output ready
	);

endinterface

// ----- sv/keyed_unique_id_generator.sv -----
// Keyed unique id generator. Every request transaction on req carries an
// instance, a function and a zone number plus the current time in seconds,
// and produces exactly one response transaction on rsp with a status and a
// 64-bit id (zero unless the status is ok). Requests are range checked first
// (instance, then function, then zone); a request that passes is looked up
// in a fully associative table of TABLE_ENTRIES keys held in flip-flops. A new
// key claims the lowest free entry, or gets no_room when the table is full;
// entries are never released. Each entry keeps the last second it served and
// a serial that restarts at zero whenever the second changes, and a key that
// has already handed out 65536 ids within one second answers busy until the
// time moves on. The block takes one request per clock cycle unless rsp
// stalls: a request is registered on acceptance, the table lookup, update
// and id packing are done from the request register, and the response
// register is loaded when the request register advances. Consecutive
// requests for the same key see each other's updates without any bubble,
// because the table read and write-back share the same cycle. On an rsp
// stall the response register holds its transaction and the request
// register one more, and req.ready drops. Reset clears only valid bits, so
// the block is ready in the first cycle after reset with no clearing pass.
module keyed_unique_id_generator (
	input  logic        clk,
	input  logic        arst_n,
	kuid_req_if.sink    req,
	kuid_rsp_if.source  rsp
);
	import kuid_pkg::*;

	// Request register.
	logic                 valid_s1;
	logic [INST_IN_W-1:0] inst_s1;
	logic [FUNC_IN_W-1:0] func_s1;
	logic [ZONE_IN_W-1:0] zone_s1;
	logic [SECONDS_W-1:0] now_s1;

	// Key table. Only the valid bits are reset; an entry's other fields are
	// never looked at before the entry has been claimed.
	entry_vec_t              entry_valid_q;
	logic [KEY_W-1:0]        entry_key_q    [TABLE_ENTRIES];
	logic [SECONDS_W-1:0]    entry_second_q [TABLE_ENTRIES];
	logic [SERIAL_CNT_W-1:0] entry_serial_q [TABLE_ENTRIES];

	// Response register.
	logic            rsp_valid_q;
	status_t         status_q;
	logic [ID_W-1:0] id_q;

	// Lookup and update logic.
	logic                    advance;
	logic                    range_ok;
	status_t                 range_status;
	logic [KEY_W-1:0]        key;
	entry_vec_t              hit_vec;
	entry_vec_t              free_vec;
	entry_vec_t              first_free;
	entry_vec_t              write_vec;
	logic                    hit;
	logic [SECONDS_W-1:0]    hit_second;
	logic [SERIAL_CNT_W-1:0] hit_serial;
	logic [SERIAL_CNT_W-1:0] cur_serial;
	logic [SERIAL_CNT_W-1:0] next_serial;
	logic                    busy;
	logic                    table_write;
	status_t                 status_d;
	logic [ID_W-1:0]         id_d;

	// The request register moves on whenever the response register is empty
	// or its transaction is being taken in this cycle.
	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			inst_s1 <= req.instance_id;
			func_s1 <= req.function_id;
			zone_s1 <= req.zone_number;
			now_s1  <= req.now_seconds;
		end
	end

	// Range checks in their fixed order: instance, function, zone. The upper
	// bit of each field set means the value is above its valid range.
	always_comb begin
		range_ok     = 1'b0;
		range_status = ST_OK;
		if (inst_s1 == '0) begin
			range_status = ST_NOT_READY;
		end else if (inst_s1[INST_IN_W-1:INST_W] != '0) begin
			range_status = ST_TOO_BIG;
		end else if (func_s1 == '0) begin
			range_status = ST_NOT_READY;
		end else if (func_s1[FUNC_IN_W-1:FUNC_W] != '0) begin
			range_status = ST_TOO_BIG;
		end else if (zone_s1[ZONE_IN_W-1:ZONE_W] != '0) begin
			range_status = ST_TOO_BIG;
		end else begin
			range_ok = 1'b1;
		end
	end

	assign key = {zone_s1[ZONE_W-1:0], func_s1[FUNC_W-1:0], inst_s1[INST_W-1:0]};

	// Parallel key compare over all entries. Keys in the table are unique, so
	// at most one entry matches and its fields can be picked with an OR mux.
	always_comb begin
		hit_second = '0;
		hit_serial = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_vec[i] = entry_valid_q[i] && (entry_key_q[i] == key);
			if (hit_vec[i]) begin
				hit_second = hit_second | entry_second_q[i];
				hit_serial = hit_serial | entry_serial_q[i];
			end
		end
	end

	assign hit = |hit_vec;

	// Lowest free entry: isolate the lowest set bit of the free vector.
	assign free_vec   = ~entry_valid_q;
	assign first_free = free_vec & (~free_vec + entry_vec_t'(1));

	// A new key starts at serial zero, and so does a known key whose second
	// has moved on.
	assign cur_serial  = (hit && (hit_second == now_s1)) ? hit_serial : '0;
	assign busy        = cur_serial[SERIAL_CNT_W-1];
	assign next_serial = busy ? cur_serial : cur_serial + SERIAL_CNT_W'(1);

	always_comb begin
		table_write = 1'b0;
		status_d    = range_status;
		id_d        = '0;
		if (range_ok) begin
			if (!hit && (free_vec == '0)) begin
				status_d = ST_NO_ROOM;
			end else begin
				// A busy key still records the current second.
				table_write = 1'b1;
				if (busy) begin
					status_d = ST_BUSY;
				end else begin
					status_d = ST_OK;
					id_d     = {now_s1[SEC_ID_W-1:0], cur_serial[SERIAL_W-1:0], key};
				end
			end
		end
	end

	assign write_vec = hit ? hit_vec : first_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (advance && table_write) begin
			entry_valid_q <= entry_valid_q | write_vec;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			if (advance && table_write && write_vec[i]) begin
				entry_key_q[i]    <= key;
				entry_second_q[i] <= now_s1;
				entry_serial_q[i] <= next_serial;
			end
		end
	end

	// Response register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			status_q <= status_d;
			id_q     <= id_d;
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.status   = status_q;
	assign rsp.id_value = id_q;

	// Entries are claimed for good: a valid bit never clears after reset.
	a_valid_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(($past(entry_valid_q) & ~entry_valid_q) == '0))
		else $error("table entry lost its valid bit");

	// At most one entry is claimed per request.
	a_one_claim: assert property (@(posedge clk) disable iff (!arst_n)
		($countones(entry_valid_q & ~$past(entry_valid_q)) <= 1))
		else $error("more than one table entry claimed in a cycle");

	// Stored keys are unique, so a lookup never matches two entries.
	a_unique_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 |-> $onehot0(hit_vec)))
		else $error("key found in more than one table entry");

	// A response that is not ok carries a zero id.
	a_zero_id: assert property (@(posedge clk) disable iff (!arst_n)
		((rsp_valid_q && (status_q != ST_OK)) |-> (id_q == '0)))
		else $error("non-zero id with a failing status");

	// A table update happens only for a request that passed its range checks.
	a_write_ok: assert property (@(posedge clk) disable iff (!arst_n)
		((advance && table_write) |-> range_ok))
		else $error("table written for an out-of-range request");

endmodule
